// ===== rtl/core/lmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types and constants for the long multiply / divide execute unit.
// ----------------------------------------------------------------------------
package lmd_pkg;

  localparam int unsigned LMD_STEPS = 64;

  localparam logic [15:0] OP_EXTB_LO  = 16'h49c0;
  localparam logic [15:0] OP_EXTB_HI  = 16'h49c7;
  localparam logic [15:0] OP_GRP_MASK = 16'hffc0;
  localparam logic [15:0] OP_MUL_L    = 16'h4c00;
  localparam logic [15:0] OP_DIV_L    = 16'h4c40;
  localparam logic [15:0] OP_WORD_MSK = 16'hffff;

  localparam logic [2:0] EA_MODE_D16 = 3'd5;
  localparam logic [2:0] EA_MODE_EXT = 3'd7;
  localparam logic [2:0] EA_REG_IMM  = 3'd4;

  localparam logic [3:0] ADV_EXTB = 4'd2;
  localparam logic [3:0] ADV_BASE = 4'd4;
  localparam logic [3:0] ADV_D16  = 4'd6;
  localparam logic [3:0] ADV_IMM  = 4'd8;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DIV0   = 2'd1,
    ST_UNHAND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_PASS = 2'd0,
    K_MUL  = 2'd1,
    K_DIV  = 2'd2
  } kind_t;

  // arithmetic state handed from cell to cell
  typedef struct packed {
    logic        div;
    logic [63:0] word;
    logic [63:0] acc;
    logic [31:0] dvs;
  } arith_t;

  // per-item control that rides along with the arithmetic
  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic        neg_lo;
    logic        neg_hi;
    logic [2:0]  dlo;
    logic [2:0]  dhi;
    logic        wh;
    logic [3:0]  adv;
    logic [31:0] direct;
  } side_t;

endpackage

// ===== rtl/core/lmd_if.sv =====
// ----------------------------------------------------------------------------
// lmd channel interfaces
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface lmd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] opcode_word;
  logic [15:0] extension_word;
  logic [31:0] low_reg_value;
  logic [31:0] high_reg_value;
  logic [31:0] source_value;

  modport source (output valid, opcode_word, extension_word, low_reg_value,
                  high_reg_value, source_value, input ready);
  modport sink   (input valid, opcode_word, extension_word, low_reg_value,
                  high_reg_value, source_value, output ready);
endinterface

interface lmd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_low;
  logic [31:0] result_high;
  logic [2:0]  low_dest_index;
  logic [2:0]  high_dest_index;
  logic        write_high;
  logic [3:0]  pc_advance;

  modport source (output valid, status, result_low, result_high, low_dest_index,
                  high_dest_index, write_high, pc_advance, input ready);
  modport sink   (input valid, status, result_low, result_high, low_dest_index,
                  high_dest_index, write_high, pc_advance, output ready);
endinterface

// ===== rtl/core/long_mul_div_execute.sv =====
// an input beat is decoded into a row of 64 registered step cells, then a
// finishing stage feeds the output register, which holds the result beat
// throughput: one instruction per cycle; the whole row advances whenever the
// output register is empty or its beat is taken
// reset: synchronous active-low rst_n clears all valid bits; no result pending
// ----------------------------------------------------------------------------
// long_mul_div_execute
// Executes EXTB.L, MULS.L/MULU.L and DIVS.L/DIVU.L on a chain of step cells.
// ----------------------------------------------------------------------------
module long_mul_div_execute import lmd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lmd_in_if.sink    in_ch,
  lmd_out_if.source out_ch
);

  logic   adv;
  logic   v   [LMD_STEPS+1];
  arith_t ar  [LMD_STEPS+1];
  side_t  sd  [LMD_STEPS+1];

  // decode
  logic [15:0] op, ext;
  logic [31:0] lowv, highv, src;
  logic        sgn, wide, dneg, sneg, is_extb;
  logic [3:0]  ea_adv;
  logic [63:0] dvd;
  logic [31:0] a_mag, m_mag, s_mag;

  always_comb begin
    op    = in_ch.opcode_word & OP_WORD_MSK;
    ext   = in_ch.extension_word;
    lowv  = in_ch.low_reg_value;
    highv = in_ch.high_reg_value;
    src   = in_ch.source_value;
    sgn   = ext[11];
    wide  = ext[10];
    is_extb = (op >= OP_EXTB_LO) && (op <= OP_EXTB_HI);
    if (op[5:3] == EA_MODE_D16) begin
      ea_adv = ADV_D16;
    end else if (op[5:3] == EA_MODE_EXT && op[2:0] == EA_REG_IMM) begin
      ea_adv = ADV_IMM;
    end else begin
      ea_adv = ADV_BASE;
    end
    a_mag = (sgn && lowv[31]) ? (~lowv + 32'd1) : lowv;
    sneg  = sgn && src[31];
    s_mag = sneg ? (~src + 32'd1) : src;
    m_mag = s_mag;
    dneg  = sgn && (wide ? highv[31] : lowv[31]);
    if (wide) begin
      dvd = dneg ? (~{highv, lowv} + 64'd1) : {highv, lowv};
    end else begin
      dvd = {32'b0, a_mag};
    end

    ar[0] = '0;
    sd[0] = '0;
    sd[0].kind   = K_PASS;
    sd[0].status = ST_UNHAND;
    if (is_extb) begin
      sd[0].status = ST_DONE;
      sd[0].direct = {{24{lowv[7]}}, lowv[7:0]};
      sd[0].dlo    = op[2:0];
      sd[0].adv    = ADV_EXTB;
    end else if ((op & OP_GRP_MASK) == OP_MUL_L) begin
      sd[0].kind   = K_MUL;
      sd[0].status = ST_DONE;
      sd[0].neg_lo = (sgn && lowv[31]) ^ sneg;
      sd[0].dlo    = ext[2:0];
      sd[0].dhi    = wide ? ext[14:12] : 3'd0;
      sd[0].wh     = wide;
      sd[0].adv    = ea_adv;
      ar[0].word   = {32'b0, a_mag};
      ar[0].dvs    = m_mag;
    end else if ((op & OP_GRP_MASK) == OP_DIV_L) begin
      if (src == 32'd0) begin
        sd[0].status = ST_DIV0;
      end else begin
        sd[0].kind   = K_DIV;
        sd[0].status = ST_DONE;
        sd[0].neg_lo = dneg ^ sneg;
        sd[0].neg_hi = dneg;
        sd[0].dlo    = ext[2:0];
        sd[0].dhi    = ext[14:12];
        sd[0].wh     = 1'b1;
        sd[0].adv    = ea_adv;
        ar[0].div    = 1'b1;
        ar[0].word   = dvd;
        ar[0].dvs    = s_mag;
      end
    end
    v[0] = in_ch.valid;
  end

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  for (genvar i = 0; i < LMD_STEPS; i++) begin : g_cell
    lmd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (v[i]),
      .in_arith  (ar[i]),
      .in_side   (sd[i]),
      .out_valid (v[i+1]),
      .out_arith (ar[i+1]),
      .out_side  (sd[i+1])
    );
  end

  // finish: sign fixup and field selection
  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] rlo_r, rlo_nxt, rhi_r, rhi_nxt;
  logic [2:0]  dlo_r, dhi_r;
  logic        wh_r;
  logic [3:0]  adv_r;
  logic [63:0] prod;
  side_t       fs;
  arith_t      fa;

  always_comb begin
    fs   = sd[LMD_STEPS];
    fa   = ar[LMD_STEPS];
    prod = fs.neg_lo ? (~fa.acc + 64'd1) : fa.acc;
    status_nxt = fs.status;
    unique case (fs.kind)
      K_MUL: begin
        rlo_nxt = prod[31:0];
        rhi_nxt = fs.wh ? prod[63:32] : 32'd0;
      end
      K_DIV: begin
        rlo_nxt = fs.neg_lo ? (~fa.word[31:0] + 32'd1) : fa.word[31:0];
        rhi_nxt = fs.neg_hi ? (~fa.acc[31:0] + 32'd1) : fa.acc[31:0];
      end
      default: begin
        rlo_nxt = fs.direct;
        rhi_nxt = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v[LMD_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      rlo_r    <= rlo_nxt;
      rhi_r    <= rhi_nxt;
      dlo_r    <= fs.dlo;
      dhi_r    <= fs.dhi;
      wh_r     <= fs.wh;
      adv_r    <= fs.adv;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.result_low      = rlo_r;
  assign out_ch.result_high     = rhi_r;
  assign out_ch.low_dest_index  = dlo_r;
  assign out_ch.high_dest_index = dhi_r;
  assign out_ch.write_high      = wh_r;
  assign out_ch.pc_advance      = adv_r;

endmodule

// ===== rtl/core/lmd_cell.sv =====
// ----------------------------------------------------------------------------
// lmd_cell
// One radix-2 step: restoring divide step or shift-add multiply step.
// ----------------------------------------------------------------------------
module lmd_cell import lmd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  arith_t in_arith,
  input  side_t  in_side,
  output logic   out_valid,
  output arith_t out_arith,
  output side_t  out_side
);

  logic        valid_r;
  arith_t      arith_r, arith_nxt;
  side_t       side_r;
  logic [32:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh    = {in_arith.acc[31:0], in_arith.word[63]};
    ge        = rem_sh >= {1'b0, in_arith.dvs};
    arith_nxt = in_arith;
    if (in_arith.div) begin
      arith_nxt.word = {in_arith.word[62:0], ge};
      arith_nxt.acc  = ge ? {32'b0, 32'(rem_sh - {1'b0, in_arith.dvs})}
                          : {32'b0, rem_sh[31:0]};
    end else begin
      arith_nxt.word = {in_arith.word[62:0], 1'b0};
      arith_nxt.acc  = {in_arith.acc[62:0], 1'b0} +
                       (in_arith.word[63] ? {32'b0, in_arith.dvs} : 64'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arith_r <= arith_nxt;
      side_r  <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_arith = arith_r;
  assign out_side  = side_r;

endmodule

// ===== rtl/core/lmd_checker.sv =====
// ----------------------------------------------------------------------------
// lmd_checker
// Port-level assertions for the long multiply / divide execute unit.
// ----------------------------------------------------------------------------
module lmd_checker import lmd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] result_low,
  input logic [31:0] result_high,
  input logic [2:0]  high_dest_index,
  input logic        write_high,
  input logic [3:0]  pc_advance
);

  // a stalled result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_low) &&
      $stable(result_high) && $stable(status))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != 2'd3)
    else $error("illegal status code");

  // error beats carry nothing else
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_DONE |-> pc_advance == 4'd0 && !write_high &&
      result_low == 32'd0)
    else $error("error beat with nonzero fields");

  a_nohigh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !write_high |-> result_high == 32'd0 && high_dest_index == 3'd0)
    else $error("high result present without write_high");

  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_DONE |-> pc_advance == ADV_EXTB ||
      pc_advance == ADV_BASE || pc_advance == ADV_D16 || pc_advance == ADV_IMM)
    else $error("bad pc advance");

endmodule

bind long_mul_div_execute lmd_checker u_lmd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .result_low      (out_ch.result_low),
  .result_high     (out_ch.result_high),
  .high_dest_index (out_ch.high_dest_index),
  .write_high      (out_ch.write_high),
  .pc_advance      (out_ch.pc_advance)
);

// ===== test/long_mul_div_execute_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// long_mul_div_execute_tb
// Drives EXTB.L, long multiply, long divide and unhandled opcode beats through
// the execute unit with random gaps on both channels and checks every result
// beat against a fixed expected result or an in-bench model of the semantics.
// ----------------------------------------------------------------------------
module long_mul_div_execute_tb;
  import lmd_pkg::*;

  typedef struct packed {
    logic [15:0] op;
    logic [15:0] ext;
    logic [31:0] lowv;
    logic [31:0] highv;
    logic [31:0] src;
  } instr_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] rlo;
    logic [31:0] rhi;
    logic [2:0]  dlo;
    logic [2:0]  dhi;
    logic        wh;
    logic [3:0]  adv;
  } outcome_t;

  typedef struct {
    instr_t   ins;
    bit       known;
    outcome_t res;
  } row_t;

  localparam int N_RANDOM = 900;
  localparam int LATENCY  = 65;
  localparam int LIMIT    = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  lmd_in_if  in_ch();
  lmd_out_if out_ch();

  long_mul_div_execute uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  outcome_t pending_results[$];
  int       errors = 0;
  int       cycles = 0;
  int       rx_gap = 0;
  bit       rx_stall_on = 1'b1;

  function automatic logic [3:0] ea_advance(logic [15:0] op);
    if (op[5:3] == EA_MODE_D16) return ADV_D16;
    if (op[5:3] == EA_MODE_EXT && op[2:0] == EA_REG_IMM) return ADV_IMM;
    return ADV_BASE;
  endfunction

  function automatic outcome_t execute(instr_t i);
    outcome_t o;
    logic        sgn, wide, nq, nr;
    logic [31:0] a, m, dvs;
    logic [63:0] p, dvd, q, r;
    o = '0;
    o.status = ST_UNHAND;
    sgn  = i.ext[11];
    wide = i.ext[10];
    if (i.op >= OP_EXTB_LO && i.op <= OP_EXTB_HI) begin
      o.rlo = {{24{i.lowv[7]}}, i.lowv[7:0]};
      o.dlo = i.op[2:0];
      o.status = ST_DONE;
      o.adv = ADV_EXTB;
    end else if ((i.op & OP_GRP_MASK) == OP_MUL_L) begin
      a = i.lowv; m = i.src; nq = 1'b0;
      if (sgn) begin
        if (a[31]) begin a = -a; nq = 1'b1; end
        if (m[31]) begin m = -m; nq = ~nq; end
      end
      p = {32'd0, a} * {32'd0, m};
      if (nq) p = -p;
      o.rlo = p[31:0];
      o.dlo = i.ext[2:0];
      if (wide) begin
        o.rhi = p[63:32];
        o.dhi = i.ext[14:12];
        o.wh = 1'b1;
      end
      o.status = ST_DONE;
      o.adv = ea_advance(i.op);
    end else if ((i.op & OP_GRP_MASK) == OP_DIV_L) begin
      if (i.src == 32'd0) begin
        o.status = ST_DIV0;
      end else begin
        dvd = wide ? {i.highv, i.lowv} : {32'd0, i.lowv};
        dvs = i.src; nq = 1'b0; nr = 1'b0;
        if (sgn) begin
          if (wide ? i.highv[31] : i.lowv[31]) begin
            nq = 1'b1; nr = 1'b1;
            // 32-bit dividend magnitude keeps a zero high word
            dvd = wide ? -dvd : {32'd0, -i.lowv};
          end
          if (dvs[31]) begin nq = ~nq; dvs = -dvs; end
        end
        q = dvd / {32'd0, dvs};
        r = dvd % {32'd0, dvs};
        o.rlo = nq ? -q[31:0] : q[31:0];
        o.rhi = nr ? -r[31:0] : r[31:0];
        o.dlo = i.ext[2:0];
        o.dhi = i.ext[14:12];
        o.wh = 1'b1;
        o.status = ST_DONE;
        o.adv = ea_advance(i.op);
      end
    end
    return o;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic instr_t random_instr();
    instr_t i;
    int k;
    i.ext = 16'($urandom); i.lowv = $urandom; i.highv = $urandom; i.src = $urandom;
    k = $urandom_range(0, 9);
    if (k < 4)      i.op = OP_MUL_L | 16'($urandom_range(0, 63));
    else if (k < 8) i.op = OP_DIV_L | 16'($urandom_range(0, 63));
    else if (k < 9) i.op = OP_EXTB_LO | 16'($urandom_range(0, 7));
    else            i.op = 16'($urandom);
    case ($urandom_range(0, 5))
      0: i.src = 32'd0;
      1: i.src = $urandom_range(1, 16);
      2: i.src = -$urandom_range(1, 16);
      3: i.highv = {32{i.lowv[31]}};
      default: ;
    endcase
    return i;
  endfunction

  row_t directed[$];

  task automatic add_row(logic [15:0] op, logic [15:0] ext, logic [31:0] lv,
                         logic [31:0] hv, logic [31:0] s, bit known,
                         outcome_t res);
    row_t r;
    r.ins = '{op, ext, lv, hv, s};
    r.known = known;
    r.res = res;
    directed.push_back(r);
  endtask

  task automatic send(instr_t i, outcome_t expected_res);
    in_ch.valid <= 1'b1;
    in_ch.opcode_word <= i.op;
    in_ch.extension_word <= i.ext;
    in_ch.low_reg_value <= i.lowv;
    in_ch.high_reg_value <= i.highv;
    in_ch.source_value <= i.src;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(expected_res);
  endtask

  task automatic send_with_gap(instr_t i, outcome_t expected_res);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    send(i, expected_res);
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    cycles <= cycles + 1;
    if (rst_n) begin
      // ready drops for gaps of random length
      if (rx_gap > 0) begin
        out_ch.ready <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_stall_on && $urandom_range(0, 3) == 0) rx_gap <= gap_len();
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing pending", $time);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_ch.status !== e.status || out_ch.result_low !== e.rlo ||
              out_ch.result_high !== e.rhi || out_ch.low_dest_index !== e.dlo ||
              out_ch.high_dest_index !== e.dhi || out_ch.write_high !== e.wh ||
              out_ch.pc_advance !== e.adv) begin
            $display("%0t: mismatch expected st=%0d lo=%h hi=%h dl=%0d dh=%0d wh=%0d adv=%0d",
                     $time, e.status, e.rlo, e.rhi, e.dlo, e.dhi, e.wh, e.adv);
            $display("%0t:          actual st=%0d lo=%h hi=%h dl=%0d dh=%0d wh=%0d adv=%0d",
                     $time, out_ch.status, out_ch.result_low, out_ch.result_high,
                     out_ch.low_dest_index, out_ch.high_dest_index,
                     out_ch.write_high, out_ch.pc_advance);
            errors++;
          end
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    outcome_t r, z;
    instr_t   ins;
    in_ch.valid = 1'b0;
    in_ch.opcode_word = '0;
    in_ch.extension_word = '0;
    in_ch.low_reg_value = '0;
    in_ch.high_reg_value = '0;
    in_ch.source_value = '0;
    out_ch.ready = 1'b0;
    z = '0;

    // extb extremes, then fixed results
    r = z; r.rlo = 32'hffffff80; r.dlo = 3'd7; r.adv = ADV_EXTB;
    add_row(OP_EXTB_HI, 16'h0000, 32'h12345680, 32'd0, 32'd0, 1, r);
    r = z; r.rlo = 32'h0000007f; r.adv = ADV_EXTB;
    add_row(OP_EXTB_LO, 16'hffff, 32'hffffff7f, 32'hffffffff, 32'hffffffff, 1, r);
    // divide by zero
    r = z; r.status = ST_DIV0;
    add_row(OP_DIV_L | 16'h003c, 16'hfc07, 32'hffffffff, 32'hffffffff, 32'd0, 1, r);
    // unhandled
    r = z; r.status = ST_UNHAND;
    add_row(16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, r);
    add_row(16'h0000, 16'h0000, 32'd0, 32'd0, 32'd0, 1, r);
    add_row(16'h49c8, 16'h0000, 32'd5, 32'd0, 32'd5, 1, r);
    // 32-bit unsigned multiply: high not written
    r = z; r.rlo = 32'd6; r.dlo = 3'd3; r.adv = ADV_BASE;
    add_row(OP_MUL_L, 16'h7003, 32'd2, 32'hffffffff, 32'd3, 1, r);
    // multiplies, every ea mode class, signed and unsigned, wide and 32-bit
    add_row(OP_MUL_L | 16'h0028, 16'h7c01, 32'hffffffff, 32'd0, 32'hffffffff, 0, z);
    add_row(OP_MUL_L | 16'h003c, 16'h3402, 32'hffffffff, 32'd0, 32'hffffffff, 0, z);
    add_row(OP_MUL_L | 16'h003b, 16'h0c05, 32'h80000000, 32'd0, 32'h80000000, 0, z);
    add_row(OP_MUL_L | 16'h0007, 16'h0806, 32'h80000000, 32'd0, 32'd7, 0, z);
    // divides: negative 32-bit dividend, overflow, same register
    add_row(OP_DIV_L, 16'h0801, 32'hfffffff9, 32'h12345678, 32'd2, 0, z);
    add_row(OP_DIV_L | 16'h0028, 16'h1c01, 32'hfffffff9, 32'hffffffff, 32'hfffffffe, 0, z);
    add_row(OP_DIV_L | 16'h003c, 16'h2402, 32'h00000000, 32'hffffffff, 32'd1, 0, z);
    add_row(OP_DIV_L | 16'h0010, 16'h0c00, 32'h00000000, 32'h80000000, 32'hffffffff, 0, z);
    add_row(OP_DIV_L | 16'h0020, 16'h0000, 32'hffffffff, 32'd0, 32'hffffffff, 0, z);
    add_row(OP_DIV_L | 16'h003f, 16'h8803, 32'h80000000, 32'd0, 32'hffffffff, 0, z);
    add_row(OP_DIV_L | 16'h0039, 16'h5005, 32'd100, 32'd0, 32'd7, 0, z);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[n]) begin
      send_with_gap(directed[n].ins,
                    directed[n].known ? directed[n].res : execute(directed[n].ins));
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        // drain fully before going on
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      rx_stall_on = !(n >= N_RANDOM / 2 && n < N_RANDOM / 2 + 150);
      ins = random_instr();
      if (n >= 2 * N_RANDOM / 3 && n < 2 * N_RANDOM / 3 + 150) send(ins, execute(ins));
      else send_with_gap(ins, execute(ins));
    end
    in_ch.valid <= 1'b0;
    rx_stall_on = 1'b1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== long_mul_div_execute.f =====
rtl/core/lmd_pkg.sv
rtl/core/lmd_if.sv
rtl/core/lmd_cell.sv
rtl/core/long_mul_div_execute.sv
rtl/core/lmd_checker.sv
test/long_mul_div_execute_tb.sv
